// ----- rtl/core/preemptive_priority_scheduler_unit_assert.svh -----
// assertion macros for the preemptive priority scheduler unit
// expects clk and rst_n in the scope of the module that expands them
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pps assertion failed");

`endif

// ----- rtl/core/pps_pkg.sv -----
// shared constants and types of the preemptive priority scheduler
// used by pps_cell and preemptive_priority_scheduler_unit
package pps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    // largest completion tick: last arrival plus every burst
    localparam int TICK_W    = $clog2((MAX_PROCS + 1) * 65536);
    localparam int OUT_W     = 21;

    // candidate handed from cell to cell during a scan
    typedef struct packed {
        logic              found;
        logic [7:0]        prio;
        logic [CNT_W-1:0]  idx;
        logic [15:0]       rem;
        logic              has_next;
        logic [15:0]       next_arr;
    } cand_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic              load;
        logic [CNT_W-1:0]  loaded_count;
        logic [15:0]       arrival;
        logic [15:0]       burst;
        logic [7:0]        prio;
        logic [TICK_W-1:0] tick;
        logic              apply;
        logic [CNT_W-1:0]  pick_idx;
        logic [15:0]       span;
        logic              shift;
        logic              hold;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/pps_cell.sv -----
// one process slot of the scheduler chain: descriptor, remaining time, results
// merges its own bid into the candidate from its neighbor; uses pps_pkg
module pps_cell (
    input  logic                        clk,
    input  pps_pkg::cell_ctrl_t         ctrl,
    input  logic [pps_pkg::CNT_W-1:0]   cell_index,
    input  pps_pkg::cand_t              cand_in,
    output pps_pkg::cand_t              cand_out,
    input  logic [pps_pkg::TICK_W-1:0]  nb_tat,
    input  logic [pps_pkg::TICK_W-1:0]  nb_wait,
    output logic [pps_pkg::TICK_W-1:0]  tat,
    output logic [pps_pkg::TICK_W-1:0]  wait_val
);

    logic [15:0]                arrival_reg;
    logic [15:0]                burst_reg;
    logic [7:0]                 prio_reg;
    logic [15:0]                rem_reg;
    logic [pps_pkg::TICK_W-1:0] cmpl_reg;
    logic [pps_pkg::TICK_W-1:0] tat_reg;
    logic [pps_pkg::TICK_W-1:0] wait_reg;
    pps_pkg::cand_t             cand_reg;
    pps_pkg::cand_t             cand_next;

    logic active;
    logic arrived;
    logic take_own;

    always_comb
    begin
        active   = (cell_index < ctrl.loaded_count) && (rem_reg != 16'd0);
        arrived  = {{(pps_pkg::TICK_W-16){1'b0}}, arrival_reg} <= ctrl.tick;
        take_own = active && arrived && (!cand_in.found || prio_reg <= cand_in.prio);
        cand_next = cand_in;
        if (take_own)
        begin
            cand_next.found = 1'b1;
            cand_next.prio  = prio_reg;
            cand_next.idx   = cell_index;
            cand_next.rem   = rem_reg;
        end
        if (active && !arrived && (!cand_in.has_next || arrival_reg < cand_in.next_arr))
        begin
            cand_next.has_next = 1'b1;
            cand_next.next_arr = arrival_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        if (ctrl.load && ctrl.loaded_count == cell_index)
        begin
            arrival_reg <= ctrl.arrival;
            burst_reg   <= ctrl.burst;
            prio_reg    <= ctrl.prio;
            rem_reg     <= ctrl.burst;
        end
        else if (ctrl.apply && ctrl.pick_idx == cell_index)
        begin
            rem_reg <= rem_reg - ctrl.span;
            if (rem_reg == ctrl.span)
            begin
                cmpl_reg <= ctrl.tick + {{(pps_pkg::TICK_W-16){1'b0}}, ctrl.span};
            end
        end
        // results follow the completion tick, then shift toward cell zero on output
        if (ctrl.shift)
        begin
            tat_reg  <= nb_tat;
            wait_reg <= nb_wait;
        end
        else if (!ctrl.hold)
        begin
            tat_reg  <= cmpl_reg - {{(pps_pkg::TICK_W-16){1'b0}}, arrival_reg};
            wait_reg <= tat_reg - {{(pps_pkg::TICK_W-16){1'b0}}, burst_reg};
        end
    end

    assign cand_out = cand_reg;
    assign tat      = tat_reg;
    assign wait_val = wait_reg;

endmodule

// ----- rtl/core/preemptive_priority_scheduler_unit.sv -----
// top level of the preemptive priority scheduler: sequencer and chain of cells
// depends on pps_pkg, pps_cell and the assertion macro header
//
// usage:
//   s_axis carries process descriptors, one beat each, in load order; tlast marks
//   the final process and starts the run. beats beyond MAX_PROCS are dropped.
//   m_axis returns one beat per loaded process in load order with turnaround and
//   waiting time; tlast marks the final result of the run.
// timing:
//   loads are taken back to back. the run is a series of scheduling decisions;
//   each decision is a scan through the registered cell chain, then a decide
//   state, plus an update state when a process runs. a decision covers
//   a whole stretch up to the next arrival or completion, so a run takes at most
//   about 2 * MAX_PROCS decisions. results then leave at one beat per cycle
//   while m_tready is high. s_tready is low from the final load until the last
//   result is in the output register.
// reset: the chain is empty and the block waits for loads.
// stall: the output register holds its beat while m_tready is low and the
//   result shift in the chain pauses with it.
`include "preemptive_priority_scheduler_unit_assert.svh"

module preemptive_priority_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // arrival_time[15:0], burst_time[31:16], priority_level[39:32]
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,   // last_process
    output logic        m_tvalid,
    input  logic        m_tready,
    // process_index[3:0], turnaround[24:4], waiting[45:25], zero fill
    output logic [47:0] m_tdata,
    output logic        m_tlast    // last_result
);

    localparam int N  = pps_pkg::MAX_PROCS;
    localparam int CW = pps_pkg::CNT_W;
    localparam int TW = pps_pkg::TICK_W;
    localparam int OW = pps_pkg::OUT_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_OUTPUT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   loaded_reg;
    logic [TW-1:0]   tick_reg;
    logic [CW-1:0]   scan_cnt_reg;
    logic [CW-1:0]   out_cnt_reg;
    logic [CW-1:0]   pick_reg;
    logic [15:0]     span_reg;
    logic            m_tvalid_reg;
    logic [47:0]     m_tdata_reg;
    logic            m_tlast_reg;

    pps_pkg::cell_ctrl_t ctrl;
    pps_pkg::cand_t      chain [N+1];
    logic [TW-1:0]       tat_w  [N+1];
    logic [TW-1:0]       wait_w [N+1];

    logic            s_fire;
    logic            out_load;
    logic [15:0]     burst_in;
    pps_pkg::cand_t  best;
    logic [TW-1:0]   gap;
    logic [15:0]     span_calc;
    logic [TW+OW-1:0] tat_ext;
    logic [TW+OW-1:0] wait_ext;
    logic [CW+3:0]   idx_ext;
    logic            out_last;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUTPUT) && (!m_tvalid_reg || m_tready);
    assign burst_in = (s_tdata[31:16] == 16'd0) ? 16'd1 : s_tdata[31:16];
    assign best     = chain[N];

    always_comb
    begin
        ctrl.load         = s_fire && (loaded_reg < CW'(N));
        ctrl.loaded_count = loaded_reg;
        ctrl.arrival      = s_tdata[15:0];
        ctrl.burst        = burst_in;
        ctrl.prio         = s_tdata[39:32];
        ctrl.tick         = tick_reg;
        ctrl.apply        = (state_reg == ST_UPDATE);
        ctrl.pick_idx     = pick_reg;
        ctrl.span         = span_reg;
        ctrl.shift        = out_load;
        // results stay put in the chain while they drain
        ctrl.hold         = (state_reg == ST_OUTPUT);
    end

    // run until the next arrival can preempt, or until the pick completes
    always_comb
    begin
        gap       = {{(TW-16){1'b0}}, best.next_arr} - tick_reg;
        span_calc = best.rem;
        if (best.has_next && gap < {{(TW-16){1'b0}}, best.rem})
        begin
            span_calc = gap[15:0];
        end
    end

    assign tat_ext  = {{OW{1'b0}}, tat_w[0]};
    assign wait_ext = {{OW{1'b0}}, wait_w[0]};
    assign idx_ext  = {4'b0000, out_cnt_reg};
    assign out_last = (out_cnt_reg + CW'(1)) == loaded_reg;

    assign chain[0]  = '0;
    assign tat_w[N]  = '0;
    assign wait_w[N] = '0;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        pps_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .cell_index (CW'(g)),
            .cand_in    (chain[g]),
            .cand_out   (chain[g+1]),
            .nb_tat     (tat_w[g+1]),
            .nb_wait    (wait_w[g+1]),
            .tat        (tat_w[g]),
            .wait_val   (wait_w[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            loaded_reg   <= '0;
            tick_reg     <= '0;
            scan_cnt_reg <= '0;
            out_cnt_reg  <= '0;
            pick_reg     <= '0;
            span_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {2'b00, wait_ext[OW-1:0], tat_ext[OW-1:0],
                                 idx_ext[3:0]};
                m_tlast_reg  <= out_last;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (ctrl.load)
                    begin
                        loaded_reg <= loaded_reg + CW'(1);
                    end
                    if (s_fire && s_tlast)
                    begin
                        tick_reg     <= '0;
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // the candidate passes through the register of every cell to reach the end
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                    if (scan_cnt_reg == CW'(N - 1))
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    scan_cnt_reg <= '0;
                    if (best.found)
                    begin
                        pick_reg  <= best.idx;
                        span_reg  <= span_calc;
                        state_reg <= ST_UPDATE;
                    end
                    else if (best.has_next)
                    begin
                        tick_reg  <= {{(TW-16){1'b0}}, best.next_arr};
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        out_cnt_reg <= '0;
                        state_reg   <= ST_OUTPUT;
                    end
                end
                ST_UPDATE:
                begin
                    tick_reg     <= tick_reg + {{(TW-16){1'b0}}, span_reg};
                    scan_cnt_reg <= '0;
                    state_reg    <= ST_SCAN;
                end
                ST_OUTPUT:
                begin
                    if (out_load)
                    begin
                        out_cnt_reg <= out_cnt_reg + CW'(1);
                        if (out_last)
                        begin
                            loaded_reg <= '0;
                            tick_reg   <= '0;
                            state_reg  <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // every applied step must make progress or the run never ends
    `PPS_ASSERT_IMPLY(a_span_nonzero, state_reg == ST_UPDATE, span_reg != 16'd0)
    // time stands still while a scan is in flight
    `PPS_ASSERT_NEXT(a_tick_held, state_reg == ST_SCAN, $stable(tick_reg))
    // results are only produced for a nonempty set
    `PPS_ASSERT_IMPLY(a_out_nonempty, state_reg == ST_OUTPUT,
                      loaded_reg != '0 && out_cnt_reg < loaded_reg)

endmodule

// ----- tb/sv/schedule_checker.sv -----
`timescale 1ns / 1ps
// checker for the preemptive priority scheduler: watches both stream channels,
// predicts turnaround and waiting time per process and compares every result beat
// depends on pps_pkg for MAX_PROCS and the result field width
module schedule_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // arrival_time[15:0], burst_time[31:16], priority_level[39:32]
    input  logic        s_tlast,   // last_process
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // process_index[3:0], turnaround[24:4], waiting[45:25], zero fill
    input  logic        m_tlast,   // last_result
    output int          fail_count,
    output int          pending_count,
    output int          checked_count,
    output int          run_count
);

    typedef struct {
        logic [3:0]                index;
        logic [pps_pkg::OUT_W-1:0] turnaround;
        logic [pps_pkg::OUT_W-1:0] waiting;
        logic                      final_beat;
    } proc_report_t;

    logic [15:0]  held_arrival [pps_pkg::MAX_PROCS];
    logic [15:0]  held_burst   [pps_pkg::MAX_PROCS];
    logic [7:0]   held_prio    [pps_pkg::MAX_PROCS];
    int           held_count = 0;
    int           fails      = 0;
    int           checked    = 0;
    int           runs       = 0;
    proc_report_t expected_reports[$];

    // plays the whole set out, jumping over idle stretches and stretches
    // that no arrival can interrupt, then queues one report per held process
    function automatic void predict_schedule();
        longint unsigned left        [pps_pkg::MAX_PROCS];
        longint unsigned finish_tick [pps_pkg::MAX_PROCS];
        longint unsigned now;
        longint unsigned next_arrival;
        longint unsigned span;
        logic [63:0]     tat;
        logic [63:0]     wait_ticks;
        logic [7:0]      best;
        int              done;
        int              pick;
        int              i;
        proc_report_t    rep;
        now  = 0;
        done = 0;
        for (i = 0; i < held_count; i++)
            left[i] = held_burst[i];
        while (done < held_count) begin
            pick         = -1;
            best         = 8'd0;
            next_arrival = '1;
            for (i = 0; i < held_count; i++) begin
                if (left[i] != 0) begin
                    if (held_arrival[i] <= now) begin
                        // ties go to the later load index
                        if (pick < 0 || held_prio[i] <= best) begin
                            best = held_prio[i];
                            pick = i;
                        end
                    end
                    else if (held_arrival[i] < next_arrival) begin
                        next_arrival = held_arrival[i];
                    end
                end
            end
            if (pick < 0) begin
                now = next_arrival;
            end
            else begin
                span = left[pick];
                if (next_arrival != '1 && next_arrival - now < span)
                    span = next_arrival - now;
                left[pick] = left[pick] - span;
                now        = now + span;
                if (left[pick] == 0) begin
                    done++;
                    finish_tick[pick] = now;
                end
            end
        end
        for (i = 0; i < held_count; i++) begin
            tat            = finish_tick[i] - held_arrival[i];
            wait_ticks     = tat - held_burst[i];
            rep.index      = 4'(i);
            rep.turnaround = tat[pps_pkg::OUT_W-1:0];
            rep.waiting    = wait_ticks[pps_pkg::OUT_W-1:0];
            rep.final_beat = (i == held_count - 1);
            expected_reports.push_back(rep);
        end
    endfunction

    always @(posedge clk) begin
        proc_report_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                // beats past a full store are dropped but a tlast still starts the run
                if (held_count < pps_pkg::MAX_PROCS) begin
                    held_arrival[held_count] = s_tdata[15:0];
                    held_burst[held_count]   = (s_tdata[31:16] == 16'd0) ? 16'd1
                                                                         : s_tdata[31:16];
                    held_prio[held_count]    = s_tdata[39:32];
                    held_count++;
                end
                if (s_tlast) begin
                    predict_schedule();
                    held_count = 0;
                    runs++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("result beat with nothing predicted: process_index %0d", m_tdata[3:0]);
                    fails++;
                end
                else begin
                    want = expected_reports.pop_front();
                    if (m_tdata[3:0] !== want.index) begin
                        $error("process_index expected %0d actual %0d", want.index, m_tdata[3:0]);
                        fails++;
                    end
                    if (m_tdata[24:4] !== want.turnaround) begin
                        $error("turnaround expected %0d actual %0d",
                               want.turnaround, m_tdata[24:4]);
                        fails++;
                    end
                    if (m_tdata[45:25] !== want.waiting) begin
                        $error("waiting expected %0d actual %0d", want.waiting, m_tdata[45:25]);
                        fails++;
                    end
                    if (m_tdata[47:46] !== 2'b00) begin
                        $error("zero fill expected 0 actual %0d", m_tdata[47:46]);
                        fails++;
                    end
                    if (m_tlast !== want.final_beat) begin
                        $error("last_result expected %0d actual %0d", want.final_beat, m_tlast);
                        fails++;
                    end
                    checked++;
                end
            end
        end
        fail_count    <= fails;
        pending_count <= expected_reports.size();
        checked_count <= checked;
        run_count     <= runs;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// top of the scheduler testbench: clock, reset, descriptor stimulus and result backpressure
// depends on preemptive_priority_scheduler_unit, pps_pkg and schedule_checker
module testbench;

    localparam int MAX_PROCS_PLUS_TWO = pps_pkg::MAX_PROCS + 2;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // arrival_time[15:0], burst_time[31:16], priority_level[39:32]
    logic        s_tlast;    // last_process
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // process_index[3:0], turnaround[24:4], waiting[45:25], zero fill
    logic        m_tlast;    // last_result

    int fail_count;
    int pending_count;
    int checked_count;
    int run_count;
    int loads_sent = 0;
    int burst_left = 0;
    bit long_hold_done = 1'b0;

    preemptive_priority_scheduler_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    schedule_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .run_count     (run_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offers one descriptor and waits for its beat; gaps come between bursts
    task automatic send_process(input logic [15:0] arrival, input logic [15:0] burst,
                                input logic [7:0] prio, input logic final_proc);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, burst, arrival};
        s_tlast  <= final_proc;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        loads_sent++;
    endtask

    // receiver: runs of different stall patterns, plus one long hold-off
    initial begin
        int mode;
        int run_len;
        m_tready = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(1, 60);
            repeat (run_len) begin
                @(posedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
            if (!long_hold_done && checked_count >= 40) begin
                // results back up, the block stops taking descriptors
                @(posedge clk);
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                long_hold_done = 1'b1;
            end
        end
    end

    initial begin
        int          k;
        int          n_procs;
        int          spread;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone process at the top of every range
        send_process(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);

        // equal priority ties, zero burst, idle gap and preemption by a later load
        send_process(16'd0,  16'd10, 8'd5,   1'b0);
        send_process(16'd3,  16'd0,  8'd5,   1'b0);
        send_process(16'd20, 16'd4,  8'd0,   1'b0);
        send_process(16'd21, 16'd2,  8'd255, 1'b0);
        send_process(16'd22, 16'd1,  8'd0,   1'b1);

        // overfull set: the last two beats are dropped, the final one still starts the run
        for (k = 0; k < MAX_PROCS_PLUS_TWO; k++)
            send_process(16'hFFFF - 16'(k), 16'hFFFF, 8'(k * 37), k == MAX_PROCS_PLUS_TWO - 1);

        while (loads_sent < 370) begin
            case ($urandom_range(0, 9))
                0:       n_procs = $urandom_range(17, 20);
                1, 2:    n_procs = $urandom_range(1, 3);
                default: n_procs = $urandom_range(4, 16);
            endcase
            spread = $urandom_range(0, 3);
            for (k = 0; k < n_procs; k++) begin
                case (spread)
                    0:       arrival = 16'($urandom);
                    1:       arrival = 16'($urandom_range(0, 15));
                    2:       arrival = 16'($urandom_range(0, 400));
                    default: arrival = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       burst = 16'h0000;
                    1:       burst = 16'hFFFF;
                    2, 3:    burst = 16'($urandom_range(1, 20));
                    default: burst = 16'($urandom);
                endcase
                prio = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
                send_process(arrival, burst, prio, k == n_procs - 1);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // let the checker take in the final beat before watching its backlog
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("summary: %0d descriptors over %0d schedule runs, %0d result beats checked",
                 loads_sent, run_count, checked_count);
        $display("summary: overfull sets, zero bursts, priority ties and a long output stall included");
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
